FILE: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and helpers for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int POOL_W   = 13;
  localparam int OFFS_W   = 12;
  localparam int STAT_W   = 2;
  localparam int LOG_W    = 4;

  localparam logic [POOL_W-1:0] POOL_RESET = 13'd4096;
  localparam logic [POOL_W-1:0] COUNT_MAX  = 13'd8191;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_DGO,
    S_DESC,
    S_PATH,
    S_PWAIT,
    S_FIND,
    S_INJ,
    S_ASC,
    S_DONE
  } state_t;

  // per-cell report toward the controller
  typedef struct packed {
    logic arrive;
    logic stuck;
    logic zero;
  } cell_rpt_t;

  // index of the highest set bit; 0 for a zero word
  function automatic logic [LOG_W-1:0] floor_log2(input logic [POOL_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 0; i < POOL_W; i++) begin
      if (v[i]) begin
        r = LOG_W'(i);
      end
    end
    return r;
  endfunction

  // smallest e with 2**e >= v, for v >= 1
  function automatic logic [LOG_W-1:0] ceil_log2(input logic [POOL_W-1:0] v);
    logic [LOG_W-1:0] r;
    if (v <= 13'd1) begin
      r = '0;
    end else begin
      r = floor_log2(v - 13'd1) + LOG_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator over a binary tree of largest-free-block codes, one
// cell per tree level, root held in the controller.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  req     | in        | req_valid / req_stall | cmd, pages, offset
//  rsp     | out       | rsp_valid / rsp_stall | status, block_offset,
//          |           |                       | granted_pages, pages_left
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data (pool_pages)
//
//  One transaction at a time. An alloc descends through the cell chain to
//  its target level, then the merged codes ascend back to the root; an
//  alloc of the whole tree skips the cell chain. A free reads its path
//  in every level cell, finds the deepest used node and ascends from it;
//  a free of the whole tree only resets the root. Each level cell makes one
//  RAM access per cycle. Refused allocs and out-of-range frees, and a free
//  that finds no used block, end without touching the tree.
//  After reset and after every pool write a clearing pass rewrites every
//  level RAM; requests are stalled meanwhile.
//  The result register lets the next transaction start while rsp is stalled;
//  a second result holds in the done state until the register frees.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
  parameter int MAX_LEAVES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        cmd,
  input  logic [bpa_pkg::POOL_W-1:0]  pages,
  input  logic [bpa_pkg::OFFS_W-1:0]  offset,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [bpa_pkg::STAT_W-1:0]  status,
  output logic [bpa_pkg::OFFS_W-1:0]  block_offset,
  output logic [bpa_pkg::POOL_W-1:0]  granted_pages,
  output logic [bpa_pkg::POOL_W-1:0]  pages_left,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bpa_pkg::POOL_W-1:0]  cfg_data
);

  // tree depth and derived widths
  localparam int L     = $clog2(MAX_LEAVES + 1) - 1;
  localparam int IW    = L;
  localparam int LW    = $clog2(L + 1);
  localparam int CW    = $clog2(L + 2);
  localparam int CNTW  = (L > 1) ? L - 1 : 1;
  localparam int ROWS  = 2 ** (L - 1);
  localparam int SUMW  = (L + 2 > 14) ? L + 2 : 14;
  localparam int PW    = bpa_pkg::POOL_W;
  localparam int OW    = bpa_pkg::OFFS_W;
  localparam int GW    = bpa_pkg::LOG_W;

  bpa_pkg::state_t state, state_next;

  // tree geometry
  logic [PW-1:0]   pool;
  logic [LW-1:0]   lt;
  logic            empty;
  logic [CW-1:0]   root;
  logic [CNTW-1:0] cnt;
  logic [PW-1:0]   counter;
  logic [PW-1:0]   counter_next;

  // current transaction
  logic            op;
  logic [PW-1:0]   eff;
  logic [OW-1:0]   offs;
  logic [GW-1:0]   sl;
  logic [CW-1:0]   sc;
  logic [LW-1:0]   tgt;
  logic [bpa_pkg::STAT_W-1:0] res_status;
  logic [OW-1:0]   res_blk;
  logic [PW-1:0]   res_granted;
  logic [SUMW-1:0] freed;
  logic [LW-1:0]   st_lvl;
  logic [CW-1:0]   st_code;

  // controller strobes
  logic clr_vld, dn_go, path_go, st_vld;
  logic req_acc, cfg_wr, out_free;

  // eval / find results
  logic fail1, fail2, out_range;
  logic [GW-1:0] lt_wr;
  logic found;
  logic [LW-1:0] f;
  logic [SUMW-1:0] sum;

  // cell chain wiring
  logic               dno_vld [1:L];
  logic [IW-1:0]      dno_idx [1:L];
  logic               dni_vld [1:L];
  logic [IW-1:0]      dni_idx [1:L];
  logic               upo_vld [1:L];
  logic [CW-1:0]      upo_code[1:L];
  logic               upi_vld [1:L];
  logic [CW-1:0]      upi_code[1:L];
  bpa_pkg::cell_rpt_t rpt     [1:L];
  logic [IW-1:0]      cidx    [1:L];
  logic [L:1]         arr_vec;
  logic               arr_any, stk_any;
  logic [IW-1:0]      arr_idx;
  logic [L:0]         zvec;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign req_acc   = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // cap the pool exponent at the tree depth
  always_comb begin
    lt_wr = bpa_pkg::floor_log2(cfg_data);
    if (lt_wr > GW'(L)) begin
      lt_wr = GW'(L);
    end
  end

  // ---- level cells ---------------------------------------------------------
  genvar k;
  generate
    for (k = 1; k <= L; k++) begin : g_cell
      if (k == 1) begin : g_head
        assign dni_vld[k] = dn_go;
        assign dni_idx[k] = '0;
      end else begin : g_link
        assign dni_vld[k] = dno_vld[k-1];
        assign dni_idx[k] = dno_idx[k-1];
      end
      if (k < L) begin : g_up
        assign upi_vld[k]  = (st_vld && st_lvl == LW'(k)) || upo_vld[k+1];
        assign upi_code[k] = (st_vld && st_lvl == LW'(k)) ? st_code : upo_code[k+1];
      end else begin : g_bottom
        assign upi_vld[k]  = st_vld && st_lvl == LW'(k);
        assign upi_code[k] = st_code;
      end

      bpa_cell #(
        .LEVEL(k),
        .IW   (IW),
        .LW   (LW),
        .CW   (CW),
        .CNTW (CNTW)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .lt      (lt),
        .tgt     (tgt),
        .sc      (sc),
        .clr_vld (clr_vld),
        .clr_cnt (cnt),
        .dn_vld  (dni_vld[k]),
        .dn_idx  (dni_idx[k]),
        .dno_vld (dno_vld[k]),
        .dno_idx (dno_idx[k]),
        .path_vld(path_go),
        .offs    (offs),
        .up_vld  (upi_vld[k]),
        .up_code (upi_code[k]),
        .upo_vld (upo_vld[k]),
        .upo_code(upo_code[k]),
        .rpt     (rpt[k]),
        .rpt_idx (cidx[k])
      );
    end
  endgenerate

  // gather cell reports; only one cell at a time holds the descent
  always_comb begin
    arr_any = 1'b0;
    stk_any = 1'b0;
    arr_idx = '0;
    zvec[0] = (root == '0);
    for (int i = 1; i <= L; i++) begin
      arr_vec[i] = rpt[i].arrive;
      arr_any    = arr_any | rpt[i].arrive;
      stk_any    = stk_any | rpt[i].stuck;
      zvec[i]    = rpt[i].zero;
      if (rpt[i].arrive) begin
        arr_idx = arr_idx | cidx[i];
      end
    end
  end

  // deepest used node on the free path, at or above the leaf level
  always_comb begin
    found = 1'b0;
    f     = '0;
    for (int i = 0; i <= L; i++) begin
      if (LW'(i) <= lt && zvec[i]) begin
        found = 1'b1;
        f     = LW'(i);
      end
    end
  end

  assign fail1     = eff > counter;
  assign fail2     = 6'(root) < (6'(sl) + 6'd1);
  assign out_range = empty || ((offs >> lt) != '0);

  // counter after the transaction completes
  always_comb begin
    sum          = SUMW'(counter) + freed;
    counter_next = counter;
    if (res_status == bpa_pkg::ST_OK) begin
      if (op == bpa_pkg::CMD_ALLOC) begin
        counter_next = (counter > res_granted) ? counter - res_granted : '0;
      end else if (sum > SUMW'(bpa_pkg::COUNT_MAX)) begin
        counter_next = bpa_pkg::COUNT_MAX;
      end else begin
        counter_next = PW'(sum);
      end
    end
  end

  // ---- next state ------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      bpa_pkg::S_CLEAR: begin
        if (cnt == CNTW'(ROWS - 1)) begin
          state_next = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        if (req_acc) begin
          state_next = bpa_pkg::S_EVAL;
        end
      end
      bpa_pkg::S_EVAL: begin
        if (op == bpa_pkg::CMD_ALLOC) begin
          if (fail1 || fail2 || (LW'(sl) == lt)) begin
            state_next = bpa_pkg::S_DONE;
          end else begin
            state_next = bpa_pkg::S_DGO;
          end
        end else if (out_range) begin
          state_next = bpa_pkg::S_DONE;
        end else begin
          state_next = bpa_pkg::S_PATH;
        end
      end
      bpa_pkg::S_DGO:   state_next = bpa_pkg::S_DESC;
      bpa_pkg::S_DESC: begin
        if (arr_any) begin
          state_next = bpa_pkg::S_INJ;
        end else if (stk_any) begin
          state_next = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_PATH:  state_next = bpa_pkg::S_PWAIT;
      bpa_pkg::S_PWAIT: state_next = bpa_pkg::S_FIND;
      bpa_pkg::S_FIND: begin
        if (!found || f == '0) begin
          state_next = bpa_pkg::S_DONE;
        end else begin
          state_next = bpa_pkg::S_INJ;
        end
      end
      bpa_pkg::S_INJ:   state_next = bpa_pkg::S_ASC;
      bpa_pkg::S_ASC: begin
        if (upo_vld[1]) begin
          state_next = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_DONE: begin
        if (out_free) begin
          state_next = bpa_pkg::S_IDLE;
        end
      end
      default: state_next = bpa_pkg::S_CLEAR;
    endcase
    // a pool write restarts the clearing pass
    if (cfg_wr) begin
      state_next = bpa_pkg::S_CLEAR;
    end
  end

  // ---- controller outputs ------------------------------------------------------
  always_comb begin
    req_stall = 1'b1;
    clr_vld   = 1'b0;
    dn_go     = 1'b0;
    path_go   = 1'b0;
    st_vld    = 1'b0;
    case (state)
      bpa_pkg::S_IDLE:  req_stall = 1'b0;
      bpa_pkg::S_CLEAR: clr_vld   = 1'b1;
      bpa_pkg::S_DGO:   dn_go     = 1'b1;
      bpa_pkg::S_PATH:  path_go   = 1'b1;
      bpa_pkg::S_INJ:   st_vld    = 1'b1;
      default: ;
    endcase
  end

  // ---- state and datapath registers ------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpa_pkg::S_CLEAR;
      cnt       <= '0;
      pool      <= bpa_pkg::POOL_RESET;
      lt        <= LW'((bpa_pkg::floor_log2(bpa_pkg::POOL_RESET) > GW'(L)) ?
                       GW'(L) : bpa_pkg::floor_log2(bpa_pkg::POOL_RESET));
      empty     <= 1'b0;
      root      <= CW'((bpa_pkg::floor_log2(bpa_pkg::POOL_RESET) > GW'(L)) ?
                       GW'(L) : bpa_pkg::floor_log2(bpa_pkg::POOL_RESET)) + CW'(1);
      counter   <= bpa_pkg::POOL_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      // advance the clearing sweep
      if (state == bpa_pkg::S_CLEAR && !cfg_wr) begin
        cnt <= cnt + CNTW'(1);
      end

      if (cfg_wr) begin
        pool    <= cfg_data;
        lt      <= LW'(lt_wr);
        empty   <= (cfg_data == '0);
        root    <= (cfg_data == '0) ? '0 : CW'(lt_wr) + CW'(1);
        counter <= cfg_data;
        cnt     <= '0;
      end else begin
        case (state)
          bpa_pkg::S_EVAL: begin
            if (op == bpa_pkg::CMD_ALLOC && !fail1 && !fail2 && LW'(sl) == lt) begin
              root <= '0;
            end
          end
          bpa_pkg::S_FIND: begin
            if (found && f == '0) begin
              root <= CW'(lt) + CW'(1);
            end
          end
          bpa_pkg::S_ASC: begin
            if (upo_vld[1]) begin
              root <= upo_code[1];
            end
          end
          bpa_pkg::S_DONE: begin
            if (out_free) begin
              counter <= counter_next;
            end
          end
          default: ;
        endcase
      end

      // result register: drop on take, load when the slot frees
      if (state == bpa_pkg::S_DONE && out_free && !cfg_wr) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end

    // payload registers
    if (req_acc) begin
      op   <= cmd;
      eff  <= (pages == '0) ? PW'(1) : pages;
      sl   <= bpa_pkg::ceil_log2((pages == '0) ? PW'(1) : pages);
      offs <= offset;
    end

    case (state)
      bpa_pkg::S_EVAL: begin
        sc          <= CW'(sl) + CW'(1);
        tgt         <= lt - LW'(sl);
        res_blk     <= '0;
        freed       <= '0;
        res_granted <= (op == bpa_pkg::CMD_ALLOC && !fail1 && !fail2) ?
                       PW'(1) << sl : '0;
        if (op == bpa_pkg::CMD_ALLOC) begin
          if (fail1) begin
            res_status <= bpa_pkg::ST_NOFREE;
          end else if (fail2) begin
            res_status <= bpa_pkg::ST_NOFIT;
          end else begin
            res_status <= bpa_pkg::ST_OK;
          end
        end else begin
          res_status <= out_range ? bpa_pkg::ST_RANGE : bpa_pkg::ST_OK;
        end
      end
      bpa_pkg::S_DESC: begin
        if (arr_any) begin
          res_blk <= OW'(arr_idx << sl);
          st_lvl  <= tgt;
          st_code <= '0;
        end else if (stk_any) begin
          res_status  <= bpa_pkg::ST_NOFIT;
          res_granted <= '0;
        end
      end
      bpa_pkg::S_FIND: begin
        if (!found) begin
          res_status <= bpa_pkg::ST_RANGE;
        end
        freed   <= SUMW'(1) << (lt - f);
        st_lvl  <= f;
        st_code <= CW'(lt) - CW'(f) + CW'(1);
      end
      default: ;
    endcase

    if (state == bpa_pkg::S_DONE && out_free) begin
      status        <= res_status;
      block_offset  <= res_blk;
      granted_pages <= res_granted;
      pages_left    <= counter_next;
    end
  end

  // ---- assertions ------------------------------------------------------------
  a_one_arrival: assert property (@(posedge clk) disable iff (rst)
    $onehot0(arr_vec))
    else $error("more than one level cell claims the alloc target");

  a_root_in_ascent: assert property (@(posedge clk) disable iff (rst)
    upo_vld[1] |-> state == bpa_pkg::S_ASC)
    else $error("ascent reached the root outside the ascent phase");

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == bpa_pkg::ST_OK && granted_pages != '0 |->
      (block_offset & OW'(granted_pages - PW'(1))) == '0)
    else $error("granted block not aligned to its size");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != bpa_pkg::ST_OK |->
      granted_pages == '0 && block_offset == '0)
    else $error("failed transaction reports a block");

  a_pool_reach: assert property (@(posedge clk) disable iff (rst)
    !empty |-> PW'(1) << lt <= pool)
    else $error("tree larger than the configured pool");

endmodule

FILE: hw/rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hw/rtl/bpa_cell.sv
// ----------------------------------------------------------------------------
// bpa_cell
// One tree level: sibling pairs of largest-free codes, descent step,
// path read and ascent merge.
// ----------------------------------------------------------------------------
module bpa_cell #(
  parameter int LEVEL = 1,
  parameter int IW    = 12,
  parameter int LW    = 4,
  parameter int CW    = 4,
  parameter int CNTW  = 11,
  localparam int DEPTH = 2 ** (LEVEL - 1),
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [LW-1:0]            lt,
  input  logic [LW-1:0]            tgt,
  input  logic [CW-1:0]            sc,
  input  logic                     clr_vld,
  input  logic [CNTW-1:0]          clr_cnt,
  input  logic                     dn_vld,
  input  logic [IW-1:0]            dn_idx,
  output logic                     dno_vld,
  output logic [IW-1:0]            dno_idx,
  input  logic                     path_vld,
  input  logic [bpa_pkg::OFFS_W-1:0] offs,
  input  logic                     up_vld,
  input  logic [CW-1:0]            up_code,
  output logic                     upo_vld,
  output logic [CW-1:0]            upo_code,
  output bpa_pkg::cell_rpt_t       rpt,
  output logic [IW-1:0]            rpt_idx
);

  logic                 pend_desc;
  logic                 pend_path;
  logic [IW-1:0]        p_lat;
  logic                 slot;
  logic [2*CW-1:0]      row;
  logic [2*CW-1:0]      rdata;
  logic [2*CW-1:0]      wdata;
  logic [AW-1:0]        addr;
  logic                 we;
  logic                 clr_wr;
  logic                 active;
  logic [CW-1:0]        fc;
  logic [CW-1:0]        init;
  logic [LW-1:0]        sh;
  logic [bpa_pkg::OFFS_W-1:0] node;
  logic [CW-1:0]        rl, rr, nl, nr, merged;
  logic                 fl, fr, c, stuck;
  logic [IW-1:0]        child;

  assign active = (LW'(LEVEL) <= lt);
  assign fc     = CW'(lt) - CW'(LEVEL) + CW'(1);
  assign init   = active ? fc : '0;
  assign sh     = lt - LW'(LEVEL);
  assign node   = offs >> sh;
  assign clr_wr = clr_vld && ((clr_cnt >> (LEVEL - 1)) == '0);

  // descent choice: smaller fitting child, left on a tie
  always_comb begin
    rl    = rdata[CW-1:0];
    rr    = rdata[2*CW-1:CW];
    fl    = (rl >= sc);
    fr    = (rr >= sc);
    stuck = 1'b0;
    c     = 1'b0;
    if (fl && fr) begin
      c = (rl <= rr) ? 1'b0 : 1'b1;
    end else if (fl) begin
      c = 1'b0;
    end else if (fr) begin
      c = 1'b1;
    end else begin
      stuck = 1'b1;
    end
  end

  assign child   = IW'({p_lat, c});
  assign dno_vld = pend_desc && !stuck && (tgt != LW'(LEVEL));
  assign dno_idx = child;
  assign rpt_idx = child;
  assign rpt.arrive = pend_desc && !stuck && (tgt == LW'(LEVEL));
  assign rpt.stuck  = pend_desc && stuck;
  assign rpt.zero   = ((slot ? row[2*CW-1:CW] : row[CW-1:0]) == '0);

  // ascent: replace the path slot, merge two full buddies
  always_comb begin
    nl = slot ? row[CW-1:0] : up_code;
    nr = slot ? up_code : row[2*CW-1:CW];
    if (nl == fc && nr == fc) begin
      merged = fc + CW'(1);
    end else begin
      merged = (nl > nr) ? nl : nr;
    end
  end

  always_comb begin
    we    = up_vld || clr_wr;
    wdata = up_vld ? {nr, nl} : {init, init};
    if (up_vld) begin
      addr = AW'(p_lat);
    end else if (clr_wr) begin
      addr = AW'(clr_cnt);
    end else if (dn_vld) begin
      addr = AW'(dn_idx);
    end else begin
      addr = AW'(node >> 1);
    end
  end

  bpa_ram #(
    .WIDTH(2 * CW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_desc <= 1'b0;
      pend_path <= 1'b0;
      upo_vld   <= 1'b0;
    end else begin
      pend_desc <= dn_vld;
      pend_path <= path_vld;
      upo_vld   <= up_vld;
    end
    upo_code <= merged;
    if (dn_vld) begin
      p_lat <= dn_idx;
    end else if (path_vld) begin
      p_lat <= IW'(node >> 1);
    end
    if (path_vld) begin
      slot <= node[0];
    end else if (pend_desc) begin
      slot <= c;
    end
    if (pend_desc || pend_path) begin
      row <= rdata;
    end
  end

endmodule
